// ===== sv/pas_pkg.sv =====
// Shared types and constants for the particle age sorter.
package pas_pkg;

    localparam int KEY_W         = 32;
    localparam int IDX_W         = 6;
    localparam int CAP_W         = 7;
    localparam int MAX_ITEMS_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [KEY_W-1:0] age_key;
        logic             is_last;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0] sorted_index;
        logic [KEY_W-1:0] sorted_age;
        logic             last_out;
    } t_out_req;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;     // take the input request, count the arrival
        logic scan_rd;    // read the entry just below the insert position
        logic shift;      // move the read entry up one slot
        logic put;        // write the new key at the insert position
        logic emit_load;  // load the output register, advance the emit pointer
        logic clear_set;  // end the set: zero counters
    } t_pas_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic keep;        // incoming request fits under the limit
        logic in_last;     // incoming request closes the set
        logic held_last;   // captured request closes the set
        logic kept_zero;   // nothing held
        logic pos_one;     // insert position is one
        logic key_gt;      // scanned key is above the new key
        logic emit_final;  // emit pointer is at the last held entry
        logic out_free;    // output register can take a result
    } t_pas_sts;

endpackage

// ===== sv/pas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pas_ctrl.sv =====
// Sequencer for loading, insertion scan and sorted emission.
module pas_ctrl
    import pas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pas_sts i_sts,
    output t_pas_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_ERD,
        S_ELD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.keep) begin
                        n_state = i_sts.kept_zero ? S_PUT : S_RD;
                    end else if (i_sts.in_last) begin
                        if (i_sts.kept_zero) begin
                            o_cmd.clear_set = 1'b1;
                        end else begin
                            n_state = S_ERD;
                        end
                    end
                end
            end
            S_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                if (i_sts.key_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.pos_one ? S_PUT : S_RD;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = i_sts.held_last ? S_ERD : S_IDLE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = i_sts.held_last ? S_ERD : S_IDLE;
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.emit_final) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.shift && o_cmd.put))
        else $error("shift and put in the same cycle");

    a_shift_then_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.shift && !i_sts.pos_one) |=> o_cmd.scan_rd)
        else $error("shift not followed by the next scan read");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_load |-> i_sts.out_free)
        else $error("output loaded while occupied");

endmodule

// ===== sv/pas_dp.sv =====
// Datapath: counters, sorted store, scan compare and output register.
module pas_dp
    import pas_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_req          i_in_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_req         o_out_req,
    input  t_pas_cmd         i_cmd,
    output t_pas_sts         o_sts
);

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int EW   = KEY_W + IDX_W;

    logic [CAP_W-1:0] r_capacity;
    logic [CW-1:0]    r_arrival;
    logic [CW-1:0]    r_kept;
    logic [CW-1:0]    r_pos;
    logic [CW-1:0]    r_k;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic             r_out_valid;
    t_out_req         r_out;

    logic [CW-1:0]    w_pos_m1;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_wdata;
    logic [EW-1:0]    w_rdata;
    logic [KEY_W-1:0] w_rkey;
    logic [IDX_W-1:0] w_ridx;

    assign w_pos_m1 = r_pos - CW'(1);
    assign w_raddr  = i_cmd.scan_rd ? w_pos_m1[AW-1:0] : r_k[AW-1:0];
    assign w_wdata  = i_cmd.shift ? w_rdata : {r_key, r_idx};
    assign w_rkey   = w_rdata[EW-1:IDX_W];
    assign w_ridx   = w_rdata[IDX_W-1:0];

    pas_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift | i_cmd.put),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_sts.keep       = (CMPW'(r_arrival) < CMPW'(r_capacity)) &&
                           (r_arrival < CW'(MAX_ITEMS));
        o_sts.in_last    = i_in_req.is_last;
        o_sts.held_last  = r_last;
        o_sts.kept_zero  = (r_kept == '0);
        o_sts.pos_one    = (r_pos == CW'(1));
        o_sts.key_gt     = (w_rkey > r_key);
        o_sts.emit_final = ((r_k + CW'(1)) == r_kept);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_arrival   <= '0;
            r_kept      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.clear_set) begin
                r_arrival <= '0;
                r_kept    <= '0;
                r_k       <= '0;
            end else begin
                if (i_cmd.accept && (r_arrival < CW'(MAX_ITEMS))) begin
                    r_arrival <= r_arrival + CW'(1);
                end
                if (i_cmd.put) begin
                    r_kept <= r_kept + CW'(1);
                end
                if (i_cmd.emit_load) begin
                    r_k <= r_k + CW'(1);
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key  <= i_in_req.age_key;
            r_last <= i_in_req.is_last;
            r_idx  <= IDX_W'(r_arrival);
            r_pos  <= r_kept;
        end else if (i_cmd.shift) begin
            r_pos <= w_pos_m1;
        end
        if (i_cmd.emit_load) begin
            r_out.sorted_index <= w_ridx;
            r_out.sorted_age   <= w_rkey;
            r_out.last_out     <= o_sts.emit_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_kept_le_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= r_arrival)
        else $error("more items held than arrived");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (r_k < r_kept))
        else $error("emit pointer beyond held items");

    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_pos != '0) && (r_pos <= r_kept))
        else $error("shift with insert position out of range");

endmodule

// ===== sv/particle_age_sorter.sv =====
// Top level of the particle age sorter: stable insertion sort of age keys.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) carries one request per
//   particle: a 32-bit age key and an is_last flag. Requests are numbered by
//   arrival from 0; only the first min(capacity, MAX_ITEMS) of a set are kept.
//   Output channel (o_out_valid / i_out_ready / o_out_req) returns, after the
//   request marked is_last, one request per kept particle in ascending age
//   order (equal ages in arrival order), with last_out on the final one.
//   i_cfg_we / i_cfg_data write the capacity register; write it only while idle.
// Sequence:
//   A request is accepted in the idle state. A kept request then costs a read
//   and a shift per stored entry with a larger age (through the single store
//   RAM port pair), plus a write at the bottom of the store, or a read, compare
//   and write when the scan stops above an equal or smaller age. A dropped
//   request needs only the accept. Emission reads each result from the store
//   RAM and then loads it; while the receiver stalls, the output register holds
//   the result and the sequencer waits. The last result may still wait in the
//   output register while the next set is being accepted.
// Reset: synchronous, active low; clears counters, sequencer and output valid,
//   capacity returns to 64. The store needs no clearing.
module particle_age_sorter
    import pas_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_pas_cmd w_cmd;
    t_pas_sts w_sts;

    // Sequencer: decides keep/drop, walks the insert scan, paces emission.
    pas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: counters, sorted store RAM and output register.
    pas_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
